/* hw/rtl/hpt_pkg.sv */
// Shared types and constants of the homogeneous point transform.
package hpt_pkg;

	localparam int COORD_W    = 32;
	localparam int FRAC_W     = 16;
	localparam int NUM_REGS   = 8;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = $clog2(NUM_REGS);
	localparam int ROWS       = 4;
	localparam int COLS       = 3;
	localparam int LANES      = 3;
	localparam int PROD_W     = 2 * COORD_W;
	localparam int ACC_W      = PROD_W + 2;
	localparam int ROW_W      = ACC_W - FRAC_W;
	localparam int MAG_W      = ROW_W;
	localparam int QUO_W      = COORD_W + 1;
	localparam int DVD_SHIFT  = QUO_W - FRAC_W;

	localparam logic [QUO_W-1:0] SAT_POS = 33'h0_7FFF_FFFF;
	localparam logic [QUO_W-1:0] SAT_NEG = 33'h0_8000_0000;

	// Identity matrix, one row pair of entries per register.
	localparam logic [CFG_DATA_W-1:0] MATRIX_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
	};

	typedef struct packed {
		logic signed [COORD_W-1:0] in_x;
		logic signed [COORD_W-1:0] in_y;
		logic signed [COORD_W-1:0] in_z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic                      divisor_zero;
		logic                      overflowed;
	} result_t;

	typedef struct packed {
		logic             valid;
		logic             zero;
		logic [LANES-1:0] neg;
	} div_ctl_t;

endpackage

/* hw/rtl/hpt_div_pipe.sv */
// Pipelined restoring divider: three numerator magnitudes over one shared divisor.
module hpt_div_pipe (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  hpt_pkg::div_ctl_t                             ctl_in,
	input  logic [hpt_pkg::LANES-1:0][hpt_pkg::MAG_W-1:0] num_in,
	input  logic [hpt_pkg::MAG_W-1:0]                     den_in,
	output hpt_pkg::div_ctl_t                             ctl_out,
	output logic [hpt_pkg::LANES-1:0][hpt_pkg::QUO_W-1:0] quo_out,
	output logic [hpt_pkg::LANES-1:0]                     sat_out
);
	import hpt_pkg::*;

	div_ctl_t                         ctl_s [QUO_W+1];
	logic [LANES-1:0][QUO_W-1:0]      quo_s [QUO_W+1];
	logic [LANES-1:0]                 sat_s [QUO_W+1];
	logic [MAG_W-1:0]                 den_s [QUO_W];
	logic [LANES-1:0][MAG_W-1:0]      rem_s [QUO_W];
	logic [LANES-1:0][QUO_W-1:0]      dvd_s [QUO_W];

	// The dividend is num * 2^16. A quotient of 2^33 or more always saturates,
	// so the leading part of the dividend is checked against the divisor once
	// and only the low 33 quotient bits are developed, one per stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den_in;
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= num_in[l] >> DVD_SHIFT;
				dvd_s[0][l] <= {num_in[l][DVD_SHIFT-1:0], {FRAC_W{1'b0}}};
				quo_s[0][l] <= '0;
				sat_s[0][l] <= (num_in[l] >> DVD_SHIFT) >= den_in;
			end
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_bit
		logic [LANES-1:0][MAG_W:0]   trial;
		logic [LANES-1:0]            ge;
		logic [LANES-1:0][QUO_W-1:0] quo_nx;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l]  = {rem_s[k-1][l], dvd_s[k-1][l][QUO_W-1]};
				ge[l]     = trial[l] >= {1'b0, den_s[k-1]};
				quo_nx[l] = {quo_s[k-1][l][QUO_W-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= quo_nx;
				sat_s[k] <= sat_s[k-1];
			end
		end

		// The last stage needs only its quotient bit, not the partial remainder.
		if (k < QUO_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k] <= den_s[k-1];
					for (int l = 0; l < LANES; l++) begin
						rem_s[k][l] <= ge[l] ? MAG_W'(trial[l] - {1'b0, den_s[k-1]})
						                     : trial[l][MAG_W-1:0];
						dvd_s[k][l] <= {dvd_s[k-1][l][QUO_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign ctl_out = ctl_s[QUO_W];
	assign quo_out = quo_s[QUO_W];
	assign sat_out = sat_s[QUO_W];

endmodule

/* hw/rtl/homogeneous_point_transform.sv */
// Top level: 4x4 homogeneous point transform with perspective divide in Q16.16.
// Stages: 3 arithmetic stages, 34 divider stages and an output register.
// Throughput: one point per cycle while point_stall is low; the divider develops one
// quotient bit per stage and a skid entry behind the output register keeps a stall
// off the pipeline for a beat.
// Reset clears all valid bits and loads the identity matrix.
module homogeneous_point_transform (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                point_valid,
	output logic                                point_stall,
	input  hpt_pkg::point_t                     point,
	output logic                                result_valid,
	input  logic                                result_stall,
	output hpt_pkg::result_t                    result,
	input  logic                                cfg_wr_en,
	input  logic [hpt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hpt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import hpt_pkg::*;

	logic [CFG_DATA_W-1:0]     matrix_q [NUM_REGS];
	logic signed [COORD_W-1:0] coef [ROWS][COLS+1];
	logic signed [COORD_W-1:0] pin [COLS];

	logic                      adv;
	logic                      v_s1, v_s2, v_s3;
	logic signed [PROD_W-1:0]  prod_s1 [ROWS][COLS];
	logic signed [ACC_W-1:0]   acc [ROWS];
	logic signed [ROW_W-1:0]   row_s2 [ROWS];
	logic [LANES-1:0][MAG_W-1:0] mag_s3;
	logic [LANES-1:0]          neg_s3;
	logic [MAG_W-1:0]          den_s3;
	logic                      zero_s3;

	div_ctl_t                    div_ctl_in, div_ctl_out;
	logic [LANES-1:0][QUO_W-1:0] quo;
	logic [LANES-1:0]            sat;

	logic [QUO_W-1:0]          limit [LANES];
	logic [QUO_W-1:0]          clamp [LANES];
	logic [LANES-1:0]          over;
	logic [COORD_W-1:0]        val [LANES];
	result_t                   fin;

	logic                      result_valid_q, skid_valid_q;
	result_t                   result_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				matrix_q[i] <= MATRIX_RESET[i];
			end
		end else if (cfg_wr_en) begin
			matrix_q[cfg_index] <= cfg_wdata;
		end
	end

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		for (genvar c = 0; c <= COLS; c++) begin : g_col
			assign coef[r][c] = matrix_q[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
		end
	end

	assign pin[0] = point.in_x;
	assign pin[1] = point.in_y;
	assign pin[2] = point.in_z;

	// The whole pipeline holds while the output buffer is full.
	assign adv         = !skid_valid_q;
	assign point_stall = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= point_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: the twelve products of the matrix with the point.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					prod_s1[r][c] <= coef[r][c] * pin[c];
				end
			end
		end
	end

	// Stage 2: exact row sums with the translation, floored to signed Q34.16.
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			acc[r] = (ACC_W'(coef[r][COLS]) <<< FRAC_W) + ACC_W'(prod_s1[r][0])
			       + ACC_W'(prod_s1[r][1]) + ACC_W'(prod_s1[r][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int r = 0; r < ROWS; r++) begin
				row_s2[r] <= acc[r][ACC_W-1:FRAC_W];
			end
		end
	end

	// Stage 3: sign and magnitude split for the divider.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				mag_s3[l] <= row_s2[l][ROW_W-1] ? MAG_W'(-row_s2[l]) : MAG_W'(row_s2[l]);
				neg_s3[l] <= row_s2[l][ROW_W-1] ^ row_s2[ROWS-1][ROW_W-1];
			end
			den_s3  <= row_s2[ROWS-1][ROW_W-1] ? MAG_W'(-row_s2[ROWS-1])
			                                   : MAG_W'(row_s2[ROWS-1]);
			zero_s3 <= row_s2[ROWS-1] == '0;
		end
	end

	assign div_ctl_in.valid = v_s3;
	assign div_ctl_in.zero  = zero_s3;
	assign div_ctl_in.neg   = neg_s3;

	hpt_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.ctl_in  (div_ctl_in),
		.num_in  (mag_s3),
		.den_in  (den_s3),
		.ctl_out (div_ctl_out),
		.quo_out (quo),
		.sat_out (sat)
	);

	// Saturate, restore the sign and apply the zero-divisor rule.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			limit[l] = div_ctl_out.neg[l] ? SAT_NEG : SAT_POS;
			over[l]  = sat[l] || (quo[l] > limit[l]);
			clamp[l] = over[l] ? limit[l] : quo[l];
			val[l]   = div_ctl_out.neg[l] ? -clamp[l][COORD_W-1:0] : clamp[l][COORD_W-1:0];
		end
		if (div_ctl_out.zero) begin
			fin.out_x        = '0;
			fin.out_y        = '0;
			fin.out_z        = '0;
			fin.divisor_zero = 1'b1;
			fin.overflowed   = 1'b0;
		end else begin
			fin.out_x        = val[0];
			fin.out_y        = val[1];
			fin.out_z        = val[2];
			fin.divisor_zero = 1'b0;
			fin.overflowed   = |over;
		end
	end

	// Output register with a skid entry behind it. The skid entry fills only
	// when the output register holds a beat that is not taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (!result_valid_q || !result_stall) begin
			if (skid_valid_q) begin
				result_valid_q <= 1'b1;
				skid_valid_q   <= 1'b0;
			end else begin
				result_valid_q <= adv && div_ctl_out.valid;
			end
		end else if (adv && div_ctl_out.valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!result_valid_q || !result_stall) begin
			if (skid_valid_q) begin
				result_q <= skid_q;
			end else if (adv && div_ctl_out.valid) begin
				result_q <= fin;
			end
		end else if (adv && div_ctl_out.valid) begin
			skid_q <= fin;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> result_valid_q)
		else $error("skid entry full while output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !result_stall) |=> !skid_valid_q)
		else $error("skid entry not drained after output beat taken");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |=> (v_s1 == $past(v_s1)) && (v_s3 == $past(v_s3)))
		else $error("pipeline moved while input stalled");

	a_zero_div_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.divisor_zero) |->
		(result.out_x == '0) && (result.out_y == '0) && (result.out_z == '0)
		&& !result.overflowed)
		else $error("zero divisor result not cleared");
`endif

endmodule
